// ===== design/slh_pkg.sv =====
// Shared types and field widths of the sparse label histogram.
package slh_pkg;

   localparam int BIN_W       = 6;
   localparam int AMOUNT_W    = 16;
   localparam int OUT_COUNT_W = 16;
   localparam int ACTIVE_W    = 7;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 40;

   typedef enum logic [1:0] {
      OP_INC   = 2'd0,
      OP_DEC   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_DUMP  = 2'd3
   } op_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_FIX,
      ST_DUMP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [3:0]             pad;
      logic [ACTIVE_W-1:0]    peak_active;
      logic [ACTIVE_W-1:0]    active_bins;
      logic [OUT_COUNT_W-1:0] out_count;
      logic [BIN_W-1:0]       out_bin;
   } rsp_data_type;

endpackage

// ===== design/slh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module slh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sparse_label_histogram_top.sv =====
// Sparse label histogram: bin counts plus a linked list of the active bins.
//
// Requests arrive on the req_ channel: req_tuser carries the operation
// (increment, decrement, clear, dump) and req_tdata the bin and amount.
// Results leave on the rsp_ channel; rsp_tlast marks the final result of a
// request. Every request gives one result except a dump of a nonempty list,
// which gives one result per active bin, newest bin first.
// All per-bin state (count, next and previous link) lives in one RAM with a
// registered read; a row of valid bits makes unwritten or cleared entries
// read as empty, so reset and clear take effect without writing the RAM.
// Each request runs a RAM read-modify-write sequence: the bin is read when
// the request is accepted and written in the modify state; linking a bin into
// a nonempty list, or unlinking a bin with a neighbor, adds a write that
// repairs each neighbor link. Clear, an empty dump and a bin out of range
// write no RAM entry; a dump does one RAM read per emitted entry.
// The first result is registered in the state entered on acceptance (modify,
// dump or emit), once the output register is free.
// A request may be accepted while an earlier result still waits in the
// output register. When the receiver stalls, the sequencer waits at the next
// result it must emit. Reset empties all bins and zeroes both counters.
module sparse_label_histogram_top
   import slh_pkg::*;
#(
   parameter int NUM_BINS    = 64,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [5:0] bin_index, [21:6] amount, [23:22] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [5:0] out_bin, [21:6] out_count, [28:22] active_bins,
   // [35:29] peak_active, [39:36] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] entry_valid, [1] op_error
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int IDX_W  = $clog2(NUM_BINS);
   localparam int LINK_W = IDX_W + 1;
   localparam int ACT_W  = $clog2(NUM_BINS + 1);
   localparam int SUM_W  = (COUNT_WIDTH > AMOUNT_W ? COUNT_WIDTH : AMOUNT_W) + 1;
   localparam logic [LINK_W-1:0] NULL_LINK = {1'b1, {IDX_W{1'b0}}};
   localparam logic [BIN_W:0]    NUM_BINS_EXT = (BIN_W + 1)'(NUM_BINS);
   localparam logic [ACT_W-1:0]  ACT_MAX = ACT_W'(NUM_BINS);
   localparam logic [ACT_W-1:0]  K_LAST = ACT_W'(NUM_BINS - 1);

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic [LINK_W-1:0]      next;
      logic [LINK_W-1:0]      prev;
   } entry_type;

   // A pending link repair of a neighbor entry.
   typedef struct packed {
      logic [IDX_W-1:0]  addr;
      logic              set_next;
      logic [LINK_W-1:0] link;
   } fix_type;

   localparam entry_type EMPTY_ENTRY = '{count: '0, next: NULL_LINK, prev: NULL_LINK};

   state_type              state_ff, state_in;
   op_code_type            op_ff, op_in;
   logic [BIN_W-1:0]       bin_ff, bin_in;
   logic [AMOUNT_W-1:0]    amount_ff, amount_in;
   logic [LINK_W-1:0]      head_ff, head_in;
   logic [ACT_W-1:0]       active_ff, active_in;
   logic [ACT_W-1:0]       peak_ff, peak_in;
   logic [NUM_BINS-1:0]    valid_ff, valid_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]       cur_ff, cur_in;
   logic [ACT_W-1:0]       k_ff, k_in;
   fix_type                fix0_ff, fix0_in;
   fix_type                fix1_ff, fix1_in;
   logic                   fix1_valid_ff, fix1_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_data_type           rsp_data_ff, rsp_data_in;
   logic [1:0]             rsp_user_ff, rsp_user_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   entry_type              ram_wr_data;
   logic                   ram_rd_en;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [$bits(entry_type)-1:0] ram_rd_data;

   logic                   req_accept;
   op_code_type            req_op;
   logic [BIN_W-1:0]       req_bin;
   logic [AMOUNT_W-1:0]    req_amount;
   logic                   req_in_range;
   logic                   out_free;
   entry_type              rd_entry;

   logic [SUM_W-1:0]       old_ext, amt_ext, sum_ext, diff_ext;
   logic                   is_inc, ovf, unf, mod_err, do_link, do_unlink;
   logic [COUNT_WIDTH-1:0] new_count;
   logic [ACT_W-1:0]       act_up;
   logic                   dump_last;

   slh_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(NUM_BINS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign req_op       = op_code_type'(req_tuser);
   assign req_bin      = req_tdata[BIN_W-1:0];
   assign req_amount   = req_tdata[BIN_W+AMOUNT_W-1:BIN_W];
   assign req_in_range = {1'b0, req_bin} < NUM_BINS_EXT;
   assign out_free     = !rsp_valid_ff || rsp_tready;

   // Entries never written since reset or the last clear read as empty.
   assign rd_entry = rd_vld_ff ? entry_type'(ram_rd_data) : EMPTY_ENTRY;

   always_comb begin
      is_inc    = (op_ff == OP_INC);
      old_ext   = SUM_W'(rd_entry.count);
      amt_ext   = SUM_W'(amount_ff);
      sum_ext   = old_ext + amt_ext;
      diff_ext  = old_ext - amt_ext;
      ovf       = |sum_ext[SUM_W-1:COUNT_WIDTH];
      unf       = amt_ext > old_ext;
      mod_err   = is_inc ? ovf : unf;
      if (mod_err) begin
         new_count = rd_entry.count;
      end else if (is_inc) begin
         new_count = sum_ext[COUNT_WIDTH-1:0];
      end else begin
         new_count = diff_ext[COUNT_WIDTH-1:0];
      end
      do_link   = is_inc && !ovf && (old_ext == '0) && (sum_ext != '0);
      do_unlink = !is_inc && !unf && (old_ext != '0) && (diff_ext == '0);
      act_up    = (active_ff < ACT_MAX) ? active_ff + 1'b1 : active_ff;
      dump_last = rd_entry.next[IDX_W] || (k_ff == K_LAST);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  OP_CLEAR: state_in = ST_EMIT;
                  OP_DUMP:  state_in = head_ff[IDX_W] ? ST_EMIT : ST_DUMP;
                  default:  state_in = req_in_range ? ST_MOD : ST_EMIT;
               endcase
            end
         end
         ST_MOD: begin
            if (out_free) begin
               if ((do_link && !head_ff[IDX_W]) ||
                   (do_unlink && !(rd_entry.prev[IDX_W] && rd_entry.next[IDX_W]))) begin
                  state_in = ST_FIX;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIX: begin
            if (!fix1_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (out_free && dump_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, RAM control and result register.
   always_comb begin
      entry_type fixed;
      fix_type   fix_p;
      fix_type   fix_n;

      op_in         = op_ff;
      bin_in        = bin_ff;
      amount_in     = amount_ff;
      head_in       = head_ff;
      active_in     = active_ff;
      peak_in       = peak_ff;
      valid_in      = valid_ff;
      cur_in        = cur_ff;
      k_in          = k_ff;
      fix0_in       = fix0_ff;
      fix1_in       = fix1_ff;
      fix1_valid_in = fix1_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = bin_ff[IDX_W-1:0];
      ram_wr_data   = EMPTY_ENTRY;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = req_bin[IDX_W-1:0];
      fixed         = rd_entry;
      fix_p         = '{addr: rd_entry.prev[IDX_W-1:0], set_next: 1'b1, link: rd_entry.next};
      fix_n         = '{addr: rd_entry.next[IDX_W-1:0], set_next: 1'b0, link: rd_entry.prev};

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_op;
               bin_in    = req_bin;
               amount_in = req_amount;
               case (req_op)
                  OP_CLEAR: begin
                     valid_in  = '0;
                     head_in   = NULL_LINK;
                     active_in = '0;
                  end
                  OP_DUMP: begin
                     ram_rd_en   = !head_ff[IDX_W];
                     ram_rd_addr = head_ff[IDX_W-1:0];
                     cur_in      = head_ff[IDX_W-1:0];
                     k_in        = '0;
                  end
                  default: begin
                     ram_rd_en = req_in_range;
                  end
               endcase
            end
         end
         ST_MOD: begin
            if (out_free) begin
               ram_wr_en = 1'b1;
               valid_in[bin_ff[IDX_W-1:0]] = 1'b1;
               fix1_valid_in = 1'b0;
               if (do_link) begin
                  ram_wr_data = '{count: new_count, next: head_ff, prev: NULL_LINK};
                  head_in     = {1'b0, bin_ff[IDX_W-1:0]};
                  active_in   = act_up;
                  peak_in     = (act_up > peak_ff) ? act_up : peak_ff;
                  fix0_in     = '{addr: head_ff[IDX_W-1:0], set_next: 1'b0,
                                  link: {1'b0, bin_ff[IDX_W-1:0]}};
                  ram_rd_en   = !head_ff[IDX_W];
               end else if (do_unlink) begin
                  ram_wr_data = EMPTY_ENTRY;
                  if (rd_entry.prev[IDX_W]) begin
                     head_in = rd_entry.next;
                  end
                  active_in     = (active_ff != '0) ? active_ff - 1'b1 : active_ff;
                  fix0_in       = rd_entry.prev[IDX_W] ? fix_n : fix_p;
                  fix1_in       = fix_n;
                  fix1_valid_in = !rd_entry.prev[IDX_W] && !rd_entry.next[IDX_W];
                  ram_rd_en     = !(rd_entry.prev[IDX_W] && rd_entry.next[IDX_W]);
               end else begin
                  ram_wr_data = '{count: new_count, next: rd_entry.next, prev: rd_entry.prev};
               end
               ram_rd_addr = fix0_in.addr;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{pad: '0,
                                peak_active: ACTIVE_W'(peak_in),
                                active_bins: ACTIVE_W'(active_in),
                                out_count: OUT_COUNT_W'(new_count),
                                out_bin: bin_ff};
               rsp_user_in  = {mod_err, 1'b1};
               rsp_last_in  = 1'b1;
            end
         end
         ST_FIX: begin
            if (fix0_ff.set_next) begin
               fixed.next = fix0_ff.link;
            end else begin
               fixed.prev = fix0_ff.link;
            end
            ram_wr_en     = 1'b1;
            ram_wr_addr   = fix0_ff.addr;
            ram_wr_data   = fixed;
            valid_in[fix0_ff.addr] = 1'b1;
            ram_rd_en     = fix1_valid_ff;
            ram_rd_addr   = fix1_ff.addr;
            fix0_in       = fix1_ff;
            fix1_valid_in = 1'b0;
         end
         ST_DUMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{pad: '0,
                                peak_active: ACTIVE_W'(peak_ff),
                                active_bins: ACTIVE_W'(active_ff),
                                out_count: OUT_COUNT_W'(rd_entry.count),
                                out_bin: BIN_W'(cur_ff)};
               rsp_user_in  = 2'b01;
               rsp_last_in  = dump_last;
               // Fetch the successor while this entry is handed off.
               ram_rd_en    = !dump_last;
               ram_rd_addr  = rd_entry.next[IDX_W-1:0];
               cur_in       = rd_entry.next[IDX_W-1:0];
               k_in         = k_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{pad: '0,
                                peak_active: ACTIVE_W'(peak_ff),
                                active_bins: ACTIVE_W'(active_ff),
                                out_count: '0,
                                out_bin: (op_ff inside {OP_INC, OP_DEC}) ?
                                         bin_ff : '0};
               rsp_user_in  = 2'b00;
               rsp_last_in  = 1'b1;
            end
         end
         default: ;
      endcase

      rd_vld_in = ram_rd_en ? valid_ff[ram_rd_addr] : rd_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= NULL_LINK;
         active_ff     <= '0;
         peak_ff       <= '0;
         valid_ff      <= '0;
         fix1_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         active_ff     <= active_in;
         peak_ff       <= peak_in;
         valid_ff      <= valid_in;
         fix1_valid_ff <= fix1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      bin_ff      <= bin_in;
      amount_ff   <= amount_in;
      rd_vld_ff   <= rd_vld_in;
      cur_ff      <= cur_in;
      k_ff        <= k_in;
      fix0_ff     <= fix0_in;
      fix1_ff     <= fix1_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff <= ACT_MAX)
      else $error("active bin count exceeds the number of bins");

   a_peak_covers_active: assert property (@(posedge clock) disable iff (reset)
      active_ff <= peak_ff)
      else $error("active bin count above its recorded peak");

   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (head_ff[IDX_W] == (active_ff == '0)))
      else $error("list head disagrees with the active bin count");

   a_dump_entry_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP && out_free) |=> (rsp_tvalid && rsp_tuser[0] && !rsp_tuser[1]))
      else $error("dumped entry not marked as a valid bin");

endmodule

// ===== bench/sparse_label_histogram_top_test.sv =====
// Self-checking testbench for the sparse label histogram with its active-bin list.
`timescale 1ns / 1ps

module sparse_label_histogram_top_test;
   import slh_pkg::*;

   localparam int        BIN_COUNT      = 64;
   localparam logic[6:0] LINK_NONE      = 7'd64;
   localparam int        RANDOM_ITEMS   = 320;
   localparam int        WATCHDOG_LIMIT = 1000;
   localparam int        DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic [BIN_W-1:0]       bin;
      logic [OUT_COUNT_W-1:0] count;
      logic [ACTIVE_W-1:0]    active;
      logic [ACTIVE_W-1:0]    peak;
      logic                   entry_valid;
      logic                   op_error;
      logic                   last;
   } hist_result_type;

   typedef struct {
      op_code_type          op;
      logic [BIN_W-1:0]     bin;
      logic [AMOUNT_W-1:0]  amount;
      bit                   typed;
      hist_result_type      result;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;

   op_code_type           req_op;
   logic [BIN_W-1:0]      req_bin;
   logic [AMOUNT_W-1:0]   req_amt;
   bit                    req_typed;
   hist_result_type       req_expected;

   // Shadow copy of the histogram and its list of active bins.
   logic [OUT_COUNT_W-1:0] tally [BIN_COUNT];
   logic [6:0]             next_bin [BIN_COUNT];
   logic [6:0]             prev_bin [BIN_COUNT];
   logic [6:0]             list_top;
   logic [ACTIVE_W-1:0]    live_bins;
   logic [ACTIVE_W-1:0]    live_peak;

   hist_result_type step_results [$];
   hist_result_type expected_results [$];

   int failures;
   int requests_accepted;
   int results_checked;
   int flagged_results;
   int longest_dump;
   int burst_left;

   assign req_tdata = {2'b00, req_amt, req_bin};
   assign req_tuser = req_op;

   sparse_label_histogram_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic hist_result_type make_result(logic [BIN_W-1:0] bin,
                                                   logic [OUT_COUNT_W-1:0] count,
                                                   logic entry_valid, logic op_error,
                                                   logic last);
      hist_result_type r;
      r.bin         = bin;
      r.count       = count;
      r.active      = live_bins;
      r.peak        = live_peak;
      r.entry_valid = entry_valid;
      r.op_error    = op_error;
      r.last        = last;
      return r;
   endfunction

   function automatic void empty_histogram();
      for (int i = 0; i < BIN_COUNT; i++) begin
         tally[i]    = '0;
         next_bin[i] = LINK_NONE;
         prev_bin[i] = LINK_NONE;
      end
      list_top  = LINK_NONE;
      live_bins = '0;
   endfunction

   // Computes the results of one request and updates the shadow state.
   function automatic void predict_histogram_step(op_code_type op, logic [BIN_W-1:0] bin,
                                                  logic [AMOUNT_W-1:0] amount);
      logic [6:0]             cur;
      logic [6:0]             nxt;
      logic [6:0]             p;
      logic [OUT_COUNT_W-1:0] old;
      logic [OUT_COUNT_W:0]   sum;
      int                     walked;
      bit                     err;
      step_results.delete();
      case (op)
         OP_CLEAR: begin
            empty_histogram();
            step_results.push_back(make_result('0, '0, 1'b0, 1'b0, 1'b1));
         end
         OP_DUMP: begin
            if (list_top == LINK_NONE) begin
               step_results.push_back(make_result('0, '0, 1'b0, 1'b0, 1'b1));
            end else begin
               walked = 0;
               cur    = list_top;
               while (cur < LINK_NONE && walked < BIN_COUNT) begin
                  nxt = next_bin[cur[5:0]];
                  step_results.push_back(make_result(cur[5:0], tally[cur[5:0]], 1'b1, 1'b0,
                                                     nxt == LINK_NONE
                                                     || walked + 1 >= BIN_COUNT));
                  walked++;
                  cur = nxt;
               end
               if (walked > longest_dump) longest_dump = walked;
            end
         end
         default: begin
            old = tally[bin];
            err = 1'b0;
            if (op == OP_INC) begin
               sum = {1'b0, old} + {1'b0, amount};
               if (sum[OUT_COUNT_W]) begin
                  err = 1'b1;
               end else begin
                  tally[bin] = sum[OUT_COUNT_W-1:0];
                  if (old == 0 && sum != 0) begin
                     prev_bin[bin] = LINK_NONE;
                     next_bin[bin] = list_top;
                     if (list_top < LINK_NONE) prev_bin[list_top[5:0]] = {1'b0, bin};
                     list_top = {1'b0, bin};
                     if (live_bins < BIN_COUNT) live_bins++;
                     if (live_bins > live_peak) live_peak = live_bins;
                  end
               end
            end else begin
               if (amount > old) begin
                  err = 1'b1;
               end else begin
                  tally[bin] = old - amount;
                  if (old != 0 && tally[bin] == 0) begin
                     p   = prev_bin[bin];
                     nxt = next_bin[bin];
                     if (p < LINK_NONE) next_bin[p[5:0]] = nxt;
                     else list_top = nxt;
                     if (nxt < LINK_NONE) prev_bin[nxt[5:0]] = p;
                     prev_bin[bin] = LINK_NONE;
                     next_bin[bin] = LINK_NONE;
                     if (live_bins > 0) live_bins--;
                  end
               end
            end
            step_results.push_back(make_result(bin, tally[bin], 1'b1, err, 1'b1));
         end
      endcase
   endfunction

   task automatic check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
         failures++;
      end
   endtask

   // Request and result monitor: predicts on every accepted request and checks
   // every accepted result against the oldest expectation.
   always @(posedge clock) begin
      hist_result_type exp_r;
      rsp_data_type    got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            requests_accepted++;
            predict_histogram_step(req_op, req_bin, req_amt);
            if (req_typed) expected_results.push_back(req_expected);
            else foreach (step_results[k]) expected_results.push_back(step_results[k]);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_results.size() == 0) begin
               $error("result with no request outstanding: bin %0d count %0d",
                      got.out_bin, got.out_count);
               failures++;
            end else begin
               exp_r = expected_results.pop_front();
               results_checked++;
               if (exp_r.op_error) flagged_results++;
               check_field("out_bin", exp_r.bin, got.out_bin);
               check_field("out_count", exp_r.count, got.out_count);
               check_field("active_bins", exp_r.active, got.active_bins);
               check_field("peak_active", exp_r.peak, got.peak_active);
               check_field("entry_valid", exp_r.entry_valid, rsp_tuser[0]);
               check_field("op_error", exp_r.op_error, rsp_tuser[1]);
               check_field("last", exp_r.last, rsp_tlast);
            end
         end
      end
   end

   // Receiver stall pattern: a mode, redrawn at random as the run goes on, is always
   // ready, random ready, mostly stalled with bounded stall runs, or a regular stall.
   initial begin
      int mode;
      int phase;
      int stalled;
      rsp_tready = 1'b0;
      mode       = 0;
      phase      = 0;
      stalled    = 0;
      forever begin
         @(negedge clock);
         if (phase % 48 == 0) mode = $urandom_range(0, 3);
         phase++;
         case (mode)
            0:       rsp_tready = 1'b1;
            1:       rsp_tready = $urandom_range(0, 1);
            2:       rsp_tready = ($urandom_range(0, 3) == 0) || stalled >= 8;
            default: rsp_tready = (phase % 5) != 0;
         endcase
         stalled = rsp_tready ? 0 : stalled + 1;
      end
   end

   // Watchdog: ends the run after too many cycles without a transaction.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("FAIL sparse_label_histogram_top");
      $finish;
   end

   // Both tasks begin and end at a falling edge.
   task automatic hold_off(int cycles);
      repeat (cycles) begin
         req_tvalid = 1'b0;
         req_op     = op_code_type'($urandom_range(0, 3));
         req_bin    = BIN_W'($urandom_range(0, 63));
         req_amt    = AMOUNT_W'($urandom_range(0, 65535));
         @(negedge clock);
      end
   endtask

   task automatic send_request(op_code_type op, logic [BIN_W-1:0] bin,
                               logic [AMOUNT_W-1:0] amount, bit typed = 1'b0,
                               hist_result_type result = '0);
      if (burst_left == 0) begin
         hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid   = 1'b1;
      req_op       = op;
      req_bin      = bin;
      req_amt      = amount;
      req_typed    = typed;
      req_expected = result;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   directed_row_type directed_rows [24] = '{
      '{OP_DUMP,  6'd0,  16'd0,     1'b1, '{6'd0,  16'd0,     7'd0, 7'd0, 1'b0, 1'b0, 1'b1}},
      '{OP_DEC,   6'd0,  16'd1,     1'b1, '{6'd0,  16'd0,     7'd0, 7'd0, 1'b1, 1'b1, 1'b1}},
      '{OP_INC,   6'd0,  16'd0,     1'b1, '{6'd0,  16'd0,     7'd0, 7'd0, 1'b1, 1'b0, 1'b1}},
      '{OP_DEC,   6'd5,  16'd0,     1'b1, '{6'd5,  16'd0,     7'd0, 7'd0, 1'b1, 1'b0, 1'b1}},
      '{OP_INC,   6'd63, 16'hFFFF,  1'b1, '{6'd63, 16'hFFFF,  7'd1, 7'd1, 1'b1, 1'b0, 1'b1}},
      '{OP_INC,   6'd63, 16'd1,     1'b1, '{6'd63, 16'hFFFF,  7'd1, 7'd1, 1'b1, 1'b1, 1'b1}},
      '{OP_INC,   6'd0,  16'd1,     1'b1, '{6'd0,  16'd1,     7'd2, 7'd2, 1'b1, 1'b0, 1'b1}},
      '{OP_INC,   6'd42, 16'h5555,  1'b1, '{6'd42, 16'h5555,  7'd3, 7'd3, 1'b1, 1'b0, 1'b1}},
      '{OP_INC,   6'd21, 16'hAAAA,  1'b1, '{6'd21, 16'hAAAA,  7'd4, 7'd4, 1'b1, 1'b0, 1'b1}},
      '{OP_DUMP,  6'd0,  16'd0,     1'b0, '0},
      '{OP_DEC,   6'd42, 16'h5555,  1'b1, '{6'd42, 16'd0,     7'd3, 7'd4, 1'b1, 1'b0, 1'b1}},
      '{OP_DEC,   6'd21, 16'hAAAA,  1'b1, '{6'd21, 16'd0,     7'd2, 7'd4, 1'b1, 1'b0, 1'b1}},
      '{OP_DEC,   6'd63, 16'hFFFF,  1'b1, '{6'd63, 16'd0,     7'd1, 7'd4, 1'b1, 1'b0, 1'b1}},
      '{OP_DUMP,  6'd0,  16'd0,     1'b0, '0},
      '{OP_INC,   6'd0,  16'd0,     1'b1, '{6'd0,  16'd1,     7'd1, 7'd4, 1'b1, 1'b0, 1'b1}},
      '{OP_DEC,   6'd0,  16'd0,     1'b1, '{6'd0,  16'd1,     7'd1, 7'd4, 1'b1, 1'b0, 1'b1}},
      '{OP_DEC,   6'd0,  16'd2,     1'b1, '{6'd0,  16'd1,     7'd1, 7'd4, 1'b1, 1'b1, 1'b1}},
      '{OP_INC,   6'd7,  16'd3,     1'b0, '0},
      '{OP_CLEAR, 6'd0,  16'd0,     1'b1, '{6'd0,  16'd0,     7'd0, 7'd4, 1'b0, 1'b0, 1'b1}},
      '{OP_DUMP,  6'd0,  16'd0,     1'b1, '{6'd0,  16'd0,     7'd0, 7'd4, 1'b0, 1'b0, 1'b1}},
      '{OP_INC,   6'd0,  16'hFFFF,  1'b1, '{6'd0,  16'hFFFF,  7'd1, 7'd4, 1'b1, 1'b0, 1'b1}},
      '{OP_DEC,   6'd0,  16'hFFFF,  1'b1, '{6'd0,  16'd0,     7'd0, 7'd4, 1'b1, 1'b0, 1'b1}},
      '{OP_CLEAR, 6'd0,  16'd0,     1'b1, '{6'd0,  16'd0,     7'd0, 7'd4, 1'b0, 1'b0, 1'b1}},
      '{OP_INC,   6'd33, 16'h8000,  1'b0, '0}
   };

   initial begin
      int                  sent;
      int                  pick;
      int                  order [BIN_COUNT];
      int                  j;
      int                  tmp;
      int                  live_list [$];
      bit                  swept;
      bit                  paused;
      logic [BIN_W-1:0]    bin;
      logic [AMOUNT_W-1:0] amount;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_op       = OP_INC;
      req_bin      = '0;
      req_amt      = '0;
      req_typed    = 1'b0;
      req_expected = '0;
      failures          = 0;
      requests_accepted = 0;
      results_checked   = 0;
      flagged_results   = 0;
      longest_dump      = 0;
      burst_left        = 0;
      live_peak         = '0;
      empty_histogram();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[r])
         send_request(directed_rows[r].op, directed_rows[r].bin, directed_rows[r].amount,
                      directed_rows[r].typed, directed_rows[r].result);

      sent   = 0;
      swept  = 1'b0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         if (!swept && sent >= 120) begin
            // Activate every bin in shuffled order, then dump the full list.
            for (int i = 0; i < BIN_COUNT; i++) order[i] = i;
            for (int i = BIN_COUNT - 1; i > 0; i--) begin
               j        = $urandom_range(0, i);
               tmp      = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            for (int i = 0; i < BIN_COUNT; i++)
               send_request(OP_INC, BIN_W'(order[i]), AMOUNT_W'($urandom_range(1, 200)));
            send_request(OP_DUMP, BIN_W'($urandom_range(0, 63)),
                         AMOUNT_W'($urandom_range(0, 65535)));
            sent  += BIN_COUNT + 1;
            swept  = 1'b1;
         end else if (!paused && sent >= 220) begin
            req_tvalid = 1'b0;
            while (expected_results.size() != 0) @(negedge clock);
            paused = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
               bin = BIN_W'(($urandom_range(0, 9) < 6) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, 63));
               case ($urandom_range(0, 19))
                  0, 1:       amount = '0;
                  2, 3, 4:    amount = AMOUNT_W'($urandom_range(0, 65535));
                  5, 6, 7:    amount = AMOUNT_W'(16'hFFFF - tally[bin]
                                       + ((tally[bin] != 0) ? $urandom_range(0, 1) : 0));
                  default:    amount = AMOUNT_W'($urandom_range(1, 400));
               endcase
               send_request(OP_INC, bin, amount);
            end else if (pick < 77) begin
               live_list.delete();
               for (int i = 0; i < BIN_COUNT; i++) if (tally[i] != 0) live_list.push_back(i);
               bin = (live_list.size() != 0)
                     ? BIN_W'(live_list[$urandom_range(0, live_list.size() - 1)])
                     : BIN_W'($urandom_range(0, 63));
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: amount = tally[bin];
                  5, 6, 7:       amount = (tally[bin] != 0)
                                          ? AMOUNT_W'($urandom_range(1, tally[bin])) : '0;
                  8:             amount = '0;
                  default:       amount = (tally[bin] == 16'hFFFF)
                                          ? tally[bin]
                                          : AMOUNT_W'(tally[bin]
                                            + $urandom_range(1, 16'hFFFF - tally[bin]));
               endcase
               send_request(OP_DEC, bin, amount);
            end else if (pick < 91) begin
               send_request(OP_DUMP, BIN_W'($urandom_range(0, 63)),
                            AMOUNT_W'($urandom_range(0, 65535)));
            end else if (pick < 94) begin
               send_request(OP_CLEAR, BIN_W'($urandom_range(0, 63)),
                            AMOUNT_W'($urandom_range(0, 65535)));
            end else begin
               send_request(op_code_type'($urandom_range(0, 3)), BIN_W'($urandom_range(0, 63)),
                            AMOUNT_W'($urandom_range(0, 65535)));
            end
            sent++;
         end
      end
      hold_off(1);

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests and %0d checked results, %0d of them flagged",
               requests_accepted, results_checked, flagged_results);
      $display("as overflow or underflow; the longest list walk had %0d bins.", longest_dump);
      if (failures == 0) begin
         $display("PASS sparse_label_histogram_top");
      end else begin
         $display("FAIL sparse_label_histogram_top");
      end
      $finish;
   end

endmodule
